>>> hw/rtl/cr3_pkg.sv
package cr3_pkg;

   localparam int OUT_W = 58;
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic       singular;
      logic [2:0] neg;
   } cr3_flags_type;

endpackage

>>> hw/rtl/cramer_3x3_solver_core.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_eq{1,2,3}_{coef_x,coef_y,coef_z,rhs}, 16b signed
// rsp      out        rsp_valid/rsp_ready  rsp_sol_{x,y,z} 58b signed Q.8, rsp_singular
//
// One system per cycle sustained while rsp_ready is held high. An accepted system passes
// 5 determinant stages, the queue, the divider input register, 3*COEF_WIDTH+2+FRAC_BITS
// quotient-bit stages and an output register before rsp_valid rises.
// Reset clears valids and queue pointers and level only. Divider stalls back up into the
// queue; the determinant front stalls only when the queue is full.
module cramer_3x3_solver_core #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [15:0]                req_eq1_coef_x,
   input  logic signed [15:0]                req_eq1_coef_y,
   input  logic signed [15:0]                req_eq1_coef_z,
   input  logic signed [15:0]                req_eq1_rhs,
   input  logic signed [15:0]                req_eq2_coef_x,
   input  logic signed [15:0]                req_eq2_coef_y,
   input  logic signed [15:0]                req_eq2_coef_z,
   input  logic signed [15:0]                req_eq2_rhs,
   input  logic signed [15:0]                req_eq3_coef_x,
   input  logic signed [15:0]                req_eq3_coef_y,
   input  logic signed [15:0]                req_eq3_coef_z,
   input  logic signed [15:0]                req_eq3_rhs,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cr3_pkg::OUT_W-1:0]  rsp_sol_x,
   output logic signed [cr3_pkg::OUT_W-1:0]  rsp_sol_y,
   output logic signed [cr3_pkg::OUT_W-1:0]  rsp_sol_z,
   output logic                              rsp_singular
);
   import cr3_pkg::*;

   localparam int CW = COEF_WIDTH;
   localparam int MAG_W = 3 * CW + 2;
   localparam int FLG_W = $bits(cr3_flags_type);
   localparam int ENT_W = 4 * MAG_W + FLG_W;

   logic [CW-1:0]          coef [3][4];
   logic                   f_valid, f_ready;
   logic [MAG_W-1:0]       f_num [3];
   logic [MAG_W-1:0]       f_den;
   cr3_flags_type          f_flags;
   logic [ENT_W-1:0]       q_in, q_out;
   logic                   q_valid, q_ready;
   logic [$clog2(FIFO_DEPTH):0] q_level;
   logic [MAG_W-1:0]       b_num [3];
   logic [MAG_W-1:0]       b_den;
   cr3_flags_type          b_flags;
   logic signed [OUT_W-1:0] sol [3];

   assign coef[0][0] = req_eq1_coef_x[CW-1:0];
   assign coef[0][1] = req_eq1_coef_y[CW-1:0];
   assign coef[0][2] = req_eq1_coef_z[CW-1:0];
   assign coef[0][3] = req_eq1_rhs[CW-1:0];
   assign coef[1][0] = req_eq2_coef_x[CW-1:0];
   assign coef[1][1] = req_eq2_coef_y[CW-1:0];
   assign coef[1][2] = req_eq2_coef_z[CW-1:0];
   assign coef[1][3] = req_eq2_rhs[CW-1:0];
   assign coef[2][0] = req_eq3_coef_x[CW-1:0];
   assign coef[2][1] = req_eq3_coef_y[CW-1:0];
   assign coef[2][2] = req_eq3_coef_z[CW-1:0];
   assign coef[2][3] = req_eq3_rhs[CW-1:0];

   cr3_det #(.COEF_WIDTH(COEF_WIDTH)) u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .coef      (coef),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .num_mag   (f_num),
      .den_mag   (f_den),
      .out_flags (f_flags)
   );

   assign q_in = {f_num[0], f_num[1], f_num[2], f_den, f_flags};

   cr3_fifo #(.WIDTH(ENT_W)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_out),
      .level      (q_level)
   );

   assign {b_num[0], b_num[1], b_num[2], b_den, b_flags} = q_out;

   cr3_div #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .num_mag   (b_num),
      .den_mag   (b_den),
      .in_flags  (b_flags),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .sol       (sol),
      .singular  (rsp_singular)
   );

   assign rsp_sol_x = sol[0];
   assign rsp_sol_y = sol[1];
   assign rsp_sol_z = sol[2];

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
      else $error("queue level beyond depth");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_sol_x == '0 && rsp_sol_y == '0 && rsp_sol_z == '0)
      else $error("singular result with nonzero solution");

   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      f_valid && !f_ready |=> f_valid && $stable(f_den))
      else $error("front result lost while queue full");

   a_accept_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> f_valid && !f_ready)
      else $error("input stalled without a full queue");

endmodule

>>> hw/rtl/cr3_det.sv
module cr3_det #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [COEF_WIDTH-1:0]       coef [3][4],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [3*COEF_WIDTH+1:0]     num_mag [3],
   output logic [3*COEF_WIDTH+1:0]     den_mag,
   output cr3_pkg::cr3_flags_type      out_flags
);
   import cr3_pkg::*;

   localparam int CW = COEF_WIDTH;
   localparam int PROD_W = 2 * CW;
   localparam int MIN_W = 2 * CW + 1;
   localparam int TERM_W = 3 * CW + 1;
   localparam int DET_W = 3 * CW + 3;
   localparam int MAG_W = DET_W - 1;

   // mat[k]: k = 0 main matrix, k = 1..3 column k-1 replaced by the rhs
   logic signed [CW-1:0]     mat    [4][3][3];
   logic signed [PROD_W-1:0] p_ff   [4][6];
   logic signed [CW-1:0]     t1_ff  [4][3];
   logic signed [MIN_W-1:0]  mn_ff  [4][3];
   logic signed [CW-1:0]     t2_ff  [4][3];
   logic signed [TERM_W-1:0] tm_ff  [4][3];
   logic signed [DET_W-1:0]  det_ff [4];
   logic signed [DET_W-1:0]  neg_det [4];
   logic [MAG_W-1:0]         mag_ff [4];
   cr3_flags_type            flg_ff;
   logic [4:0]               v_ff;
   logic                     en;

   genvar k, r, c;
   generate
      for (k = 0; k < 4; k++) begin : g_mat
         for (r = 0; r < 3; r++) begin : g_row
            for (c = 0; c < 3; c++) begin : g_col
               assign mat[k][r][c] = $signed(coef[r][(k != 0 && c == k - 1) ? 3 : c]);
            end
         end
         assign neg_det[k] = -det_ff[k];
      end
   endgenerate

   assign en = !v_ff[4] || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            p_ff[i][0] <= mat[i][1][1] * mat[i][2][2];
            p_ff[i][1] <= mat[i][2][1] * mat[i][1][2];
            p_ff[i][2] <= mat[i][1][0] * mat[i][2][2];
            p_ff[i][3] <= mat[i][2][0] * mat[i][1][2];
            p_ff[i][4] <= mat[i][1][0] * mat[i][2][1];
            p_ff[i][5] <= mat[i][2][0] * mat[i][1][1];
            for (int j = 0; j < 3; j++) begin
               t1_ff[i][j] <= mat[i][0][j];
               mn_ff[i][j] <= MIN_W'(p_ff[i][2*j]) - MIN_W'(p_ff[i][2*j+1]);
               t2_ff[i][j] <= t1_ff[i][j];
               tm_ff[i][j] <= t2_ff[i][j] * mn_ff[i][j];
            end
            det_ff[i] <= DET_W'(tm_ff[i][0]) - DET_W'(tm_ff[i][1]) + DET_W'(tm_ff[i][2]);
            mag_ff[i] <= det_ff[i][DET_W-1] ? neg_det[i][MAG_W-1:0] : det_ff[i][MAG_W-1:0];
         end
         flg_ff.singular <= (det_ff[0] == '0);
         for (int j = 0; j < 3; j++) begin
            flg_ff.neg[j] <= det_ff[0][DET_W-1] ^ det_ff[j+1][DET_W-1];
         end
      end
   end

   assign out_valid = v_ff[4];
   assign den_mag = mag_ff[0];
   assign num_mag[0] = mag_ff[1];
   assign num_mag[1] = mag_ff[2];
   assign num_mag[2] = mag_ff[3];
   assign out_flags = flg_ff;

endmodule

>>> hw/rtl/cr3_fifo.sv
module cr3_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data,
   output logic [$clog2(cr3_pkg::FIFO_DEPTH):0] level
);
   import cr3_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);

   logic [WIDTH-1:0] mem [FIFO_DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;
   logic             push, pop;

   assign push_ready = (cnt_ff != (AW+1)'(FIFO_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_data = mem[rd_ff];
   assign level = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/cr3_div.sv
module cr3_div #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [3*COEF_WIDTH+1:0]           num_mag [3],
   input  logic [3*COEF_WIDTH+1:0]           den_mag,
   input  cr3_pkg::cr3_flags_type            in_flags,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [cr3_pkg::OUT_W-1:0]  sol [3],
   output logic                              singular
);
   import cr3_pkg::*;

   localparam int MAG_W = 3 * COEF_WIDTH + 2;
   localparam int NUM_W = MAG_W + FRAC_BITS;
   localparam int EXT_W = (NUM_W + 1 > OUT_W) ? NUM_W + 1 : OUT_W;

   // one quotient bit per stage, three lanes sharing the divisor
   logic [MAG_W-1:0] rem_ff [NUM_W+1][3];
   logic [NUM_W-1:0] dvd_ff [NUM_W+1][3];
   logic [MAG_W-1:0] den_ff [NUM_W+1];
   cr3_flags_type    flg_ff [NUM_W+1];
   logic [NUM_W:0]   v_ff;
   logic             ov_ff;
   logic             en;
   logic signed [OUT_W-1:0] sol_ff [3];
   logic             sing_ff;
   logic signed [NUM_W:0]   sq [3];
   logic signed [EXT_W-1:0] ext [3];

   assign en = !ov_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[0][l] <= '0;
            dvd_ff[0][l] <= NUM_W'(num_mag[l]) << FRAC_BITS;
         end
         den_ff[0] <= den_mag;
         flg_ff[0] <= in_flags;
      end
   end

   genvar i, l;
   generate
      for (i = 1; i <= NUM_W; i++) begin : g_stage
         logic [MAG_W:0]   r2 [3];
         logic             ge [3];
         logic [MAG_W:0]   nr [3];
         for (l = 0; l < 3; l++) begin : g_lane
            assign r2[l] = {rem_ff[i-1][l], dvd_ff[i-1][l][NUM_W-1]};
            assign ge[l] = (r2[l] >= {1'b0, den_ff[i-1]});
            assign nr[l] = ge[l] ? r2[l] - {1'b0, den_ff[i-1]} : r2[l];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               for (int j = 0; j < 3; j++) begin
                  rem_ff[i][j] <= nr[j][MAG_W-1:0];
                  dvd_ff[i][j] <= {dvd_ff[i-1][j][NUM_W-2:0], ge[j]};
               end
               den_ff[i] <= den_ff[i-1];
               flg_ff[i] <= flg_ff[i-1];
            end
         end
      end
      for (l = 0; l < 3; l++) begin : g_sign
         assign sq[l] = flg_ff[NUM_W].neg[l] ? -$signed({1'b0, dvd_ff[NUM_W][l]})
                                             : $signed({1'b0, dvd_ff[NUM_W][l]});
         assign ext[l] = EXT_W'(sq[l]);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff <= {v_ff[NUM_W-1:0], in_valid};
         ov_ff <= v_ff[NUM_W];
      end
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            sol_ff[j] <= flg_ff[NUM_W].singular ? '0 : ext[j][OUT_W-1:0];
         end
         sing_ff <= flg_ff[NUM_W].singular;
      end
   end

   assign out_valid = ov_ff;
   assign sol = sol_ff;
   assign singular = sing_ff;

endmodule

>>> tb/sv/tb_cramer_3x3_solver_core.sv
`timescale 1ns / 100ps

module tb_cramer_3x3_solver_core;
   import cr3_pkg::*;

   localparam int NUM_RANDOM = 1925;
   localparam int DRAIN_CYCLES = 120;
   localparam logic signed [15:0] CMAX = 16'sh7fff;
   localparam logic signed [15:0] CMIN = -16'sh8000;

   typedef logic signed [15:0] coef_type;

   typedef struct {
      coef_type c[12];
   } system_type;

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic                    singular;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coef_type req_c[12] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_sol_x, rsp_sol_y, rsp_sol_z;
   logic rsp_singular;

   system_type   pending_systems[$];
   solution_type expected_solutions[$];
   int        idle_mode = 0;   // 0: sender 14/rcv 48, 1: swapped, 2: none
   bit        hold_sender = 1'b0;
   bit        stim_done = 1'b0;
   int        error_count = 0;

   always #1 clock = ~clock;

   cramer_3x3_solver_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_eq1_coef_x(req_c[0]), .req_eq1_coef_y(req_c[1]),
      .req_eq1_coef_z(req_c[2]), .req_eq1_rhs(req_c[3]),
      .req_eq2_coef_x(req_c[4]), .req_eq2_coef_y(req_c[5]),
      .req_eq2_coef_z(req_c[6]), .req_eq2_rhs(req_c[7]),
      .req_eq3_coef_x(req_c[8]), .req_eq3_coef_y(req_c[9]),
      .req_eq3_coef_z(req_c[10]), .req_eq3_rhs(req_c[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sol_x(rsp_sol_x), .rsp_sol_y(rsp_sol_y),
      .rsp_sol_z(rsp_sol_z), .rsp_singular(rsp_singular)
   );

   function automatic longint det3(longint a1, longint b1, longint c1,
                                   longint a2, longint b2, longint c2,
                                   longint a3, longint b3, longint c3);
      return a1 * (b2 * c3 - b3 * c2) - b1 * (a2 * c3 - a3 * c2)
           + c1 * (a2 * b3 - a3 * b2);
   endfunction

   function automatic solution_type solve_system(system_type s);
      longint v[12];
      longint d, dx, dy, dz;
      solution_type r;
      foreach (v[i]) v[i] = s.c[i];
      d  = det3(v[0], v[1], v[2], v[4], v[5], v[6], v[8], v[9], v[10]);
      dx = det3(v[3], v[1], v[2], v[7], v[5], v[6], v[11], v[9], v[10]);
      dy = det3(v[0], v[3], v[2], v[4], v[7], v[6], v[8], v[11], v[10]);
      dz = det3(v[0], v[1], v[3], v[4], v[5], v[7], v[8], v[9], v[11]);
      r.singular = (d == 0);
      if (d == 0) begin
         r.x = '0; r.y = '0; r.z = '0;
      end else begin
         // SV signed division truncates toward zero
         r.x = OUT_W'((dx * 256) / d);
         r.y = OUT_W'((dy * 256) / d);
         r.z = OUT_W'((dz * 256) / d);
      end
      return r;
   endfunction

   function automatic coef_type rand_coef(int mode);
      case (mode)
         0: return coef_type'($urandom);
         1: return coef_type'($urandom_range(0, 16)) - 8;
         2: return $urandom_range(0, 1) ? CMAX - coef_type'($urandom_range(0, 3))
                                        : CMIN + coef_type'($urandom_range(0, 3));
         default: return coef_type'($urandom_range(0, 512)) - 256;
      endcase
   endfunction

   function automatic system_type random_system();
      system_type s;
      int kind;
      int mode;
      kind = $urandom_range(0, 9);
      mode = $urandom_range(0, 3);
      foreach (s.c[i]) s.c[i] = rand_coef($urandom_range(0, 3) == 0 ? 0 : mode);
      // force singular systems (unless a negated entry is CMIN): duplicate or negate a row, or zero a column
      if (kind == 0) begin
         for (int i = 0; i < 3; i++) s.c[8 + i] = s.c[i];
      end else if (kind == 1) begin
         for (int i = 0; i < 3; i++) s.c[4 + i] = -s.c[i];
      end else if (kind == 2) begin
         s.c[1] = 0; s.c[5] = 0; s.c[9] = 0;
      end
      return s;
   endfunction

   function automatic system_type make_system(coef_type a1, coef_type b1, coef_type c1,
                                              coef_type d1, coef_type a2, coef_type b2,
                                              coef_type c2, coef_type d2, coef_type a3,
                                              coef_type b3, coef_type c3, coef_type d3);
      system_type s;
      s.c = '{a1, b1, c1, d1, a2, b2, c2, d2, a3, b3, c3, d3};
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      bit idle;
      if (!reset) begin
         if (!req_valid || req_ready) begin
            idle = (idle_mode == 0) ? ($urandom_range(0, 99) < 14)
                 : (idle_mode == 1) ? ($urandom_range(0, 99) < 48) : 1'b0;
            if (pending_systems.size() > 0 && !idle && !hold_sender) begin
               system_type s;
               s = pending_systems.pop_front();
               req_c <= s.c;
               req_valid <= 1'b1;
               expected_solutions.push_back(solve_system(s));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= (idle_mode == 0) ? ($urandom_range(0, 99) >= 48)
                    : (idle_mode == 1) ? ($urandom_range(0, 99) >= 14) : 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      solution_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_solutions.size() == 0) begin
            $display("%0t: unexpected transaction x=%0d y=%0d z=%0d singular=%0b",
                     $time, rsp_sol_x, rsp_sol_y, rsp_sol_z, rsp_singular);
            error_count++;
         end else begin
            e = expected_solutions.pop_front();
            if (rsp_sol_x !== e.x) begin
               $display("%0t: sol_x expected %0d actual %0d", $time, e.x, rsp_sol_x);
               error_count++;
            end
            if (rsp_sol_y !== e.y) begin
               $display("%0t: sol_y expected %0d actual %0d", $time, e.y, rsp_sol_y);
               error_count++;
            end
            if (rsp_sol_z !== e.z) begin
               $display("%0t: sol_z expected %0d actual %0d", $time, e.z, rsp_sol_z);
               error_count++;
            end
            if (rsp_singular !== e.singular) begin
               $display("%0t: singular expected %0b actual %0b",
                        $time, e.singular, rsp_singular);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, extremes, singular, sign mixes
      pending_systems.push_back(make_system(1, 0, 0, 5, 0, 1, 0, -7, 0, 0, 1, 3));
      pending_systems.push_back(make_system(CMAX, 0, 0, CMIN, 0, CMAX, 0, CMAX,
                                            0, 0, CMAX, 1));
      pending_systems.push_back(make_system(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX,
                                            CMIN, CMIN, CMIN, CMAX, CMAX));
      pending_systems.push_back(make_system(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                            CMIN, CMIN, CMIN, CMIN, CMIN));
      pending_systems.push_back(make_system(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_systems.push_back(make_system(1, 2, 3, 4, 2, 4, 6, 8, 1, 1, 1, 1));
      pending_systems.push_back(make_system(1, 0, 0, CMIN, 0, 1, 0, CMIN,
                                            0, 0, 1, CMIN));
      pending_systems.push_back(make_system(CMIN, 1, 0, CMAX, 1, CMIN, 0, CMAX,
                                            0, 0, -1, CMIN));
      pending_systems.push_back(make_system(3, 0, 0, 1, 0, 3, 0, -1, 0, 0, -3, 1));
      pending_systems.push_back(make_system(-3, 0, 0, -1, 0, 7, 0, 2, 0, 0, -7, -2));
      pending_systems.push_back(make_system(CMAX, CMAX, 0, 1, CMAX, CMIN, 0, -1,
                                            0, 0, CMIN, CMAX));
      pending_systems.push_back(make_system(-1, -1, -1, -1, -1, -1, -1, -1,
                                            -1, -1, -1, -1));
      pending_systems.push_back(make_system(1, 1, 1, CMAX, 0, 0, 0, 0, 2, 3, 4, CMIN));
      pending_systems.push_back(make_system(0, 0, 1, CMAX, 0, 1, 0, CMAX,
                                            1, 0, 0, CMAX));
      for (int i = 0; i < NUM_RANDOM / 2; i++)
         pending_systems.push_back(random_system());
      wait (pending_systems.size() == 0);

      // sender holds off until the pipeline drains completely
      hold_sender = 1'b1;
      wait (expected_solutions.size() == 0);
      hold_sender = 1'b0;

      idle_mode = 1;
      for (int i = 0; i < NUM_RANDOM / 4; i++)
         pending_systems.push_back(random_system());
      wait (pending_systems.size() == 0);
      idle_mode = 2;
      for (int i = 0; i < NUM_RANDOM / 4; i++)
         pending_systems.push_back(random_system());
      wait (pending_systems.size() == 0);
      @(posedge clock iff (!req_valid || req_ready));
      @(posedge clock);
      wait (expected_solutions.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
